// File: rtl/hzcd_pkg.sv
// package for the hysteresis zero-crossing detector: widths, limits and defaults
package hzcd_pkg;

    // default values of the top-level parameters
    localparam int CHANNELS_DEFAULT    = 2;
    localparam int MAX_BLOCK_DEFAULT   = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 24;

    // fixed field widths
    localparam int THR_W   = 23;
    localparam int COUNT_W = 32;
    localparam int POS_W   = 12;
    localparam int FRAC_W  = 16;
    localparam int PADDR_W = 3;

    // hysteresis level after reset, about 1e-4 in Q0.23
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(839);

    // saturated fraction, 0.99999 truncated to Q0.16
    localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [PADDR_W-3:0] REG_THRESHOLD = '0;

endpackage

// File: rtl/hysteresis_zero_cross_detector.sv
// hysteresis zero-crossing detector with serial-divider crossing interpolation
//
//  port group   direction  handshake              payload
//  input        in         in_valid / in_stall    channel, sample, block_end
//  result       out        out_valid / out_stall  crossing, upward, crossing_count,
//                                                 position, fraction, out_channel
//  config       in         apb psel/penable       threshold at byte address 0
//
// a beat that needs division goes through evaluate, FRAC_W restoring steps on the
// shared subtractor and the load into the result register; without a crossing or
// with a saturated or zero fraction it goes straight from evaluate to the load;
// in_stall stays high until the load, so the next beat is taken only after it.
// reset (rst_n, asynchronous) clears all channel state and sets threshold to 839.
// the finish step waits only while the previous result is still held under out_stall.
module hysteresis_zero_cross_detector
    import hzcd_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEFAULT,
    parameter int MAX_BLOCK   = MAX_BLOCK_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          channel,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          block_end,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          crossing,
    output logic                          upward,
    output logic [COUNT_W-1:0]            crossing_count,
    output logic [POS_W-1:0]              position,
    output logic [FRAC_W-1:0]             fraction,
    output logic                          out_channel,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW    = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
    localparam int STEP_W = $clog2(FRAC_W);
    localparam int POS_LIMIT_INT = ((MAX_BLOCK - 1) < 4095) ? (MAX_BLOCK - 1) : 4095;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_INT);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [THR_W-1:0]          threshold_reg, threshold_next;

    // per-channel state
    logic [COUNT_W-1:0]          count_reg [CHANNELS];
    logic [COUNT_W-1:0]          count_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] prev_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] prev_next [CHANNELS];
    logic [POS_W-1:0]            bpos_reg [CHANNELS];
    logic [POS_W-1:0]            bpos_next [CHANNELS];

    // captured input beat
    logic                          ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          last_reg, last_next;

    // result under construction
    logic                 hit_reg, hit_next;
    logic                 up_reg, up_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    // divider
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        den_reg, den_next;
    logic [FRAC_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 crossing_reg, crossing_next;
    logic                 upward_reg, upward_next;
    logic [COUNT_W-1:0]   crossing_count_reg, crossing_count_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [FRAC_W-1:0]    fraction_reg, fraction_next;
    logic                 out_channel_reg, out_channel_next;

    // evaluate-step signals
    logic [CH_W-1:0]      ch_idx;
    logic                 ch_ok;
    logic                 waiting_fall;
    logic signed [DW-1:0] x_ext, prev_ext, thr_ext, num, den;
    logic                 hit_up, hit_dn, hit;
    logic [DW:0]          rem_shift, rem_diff;
    logic                 in_take, cfg_write;

    // channel lookup and crossing decision
    assign ch_idx       = CH_W'(ch_reg);
    assign ch_ok        = (CHANNELS > 1) || !ch_reg;
    assign waiting_fall = count_reg[ch_idx][0];
    assign x_ext        = DW'(sample_reg);
    assign prev_ext     = DW'(prev_reg[ch_idx]);
    assign thr_ext      = signed'(DW'(threshold_reg));
    assign hit_up       = ch_ok && !waiting_fall && (x_ext >= thr_ext);
    assign hit_dn       = ch_ok && waiting_fall && (x_ext <= -thr_ext);
    assign hit          = hit_up || hit_dn;
    assign num          = hit_dn ? (-x_ext - thr_ext) : (x_ext - thr_ext);
    assign den          = hit_dn ? (prev_ext - x_ext) : (x_ext - prev_ext);

    // shared subtractor of the restoring divider
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_THRESHOLD);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_THRESHOLD) ? 32'(threshold_reg) : 32'd0;

    // next-state logic
    always_comb
    begin
        state_next          = state_reg;
        threshold_next      = threshold_reg;
        count_next          = count_reg;
        prev_next           = prev_reg;
        bpos_next           = bpos_reg;
        ch_next             = ch_reg;
        sample_next         = sample_reg;
        last_next           = last_reg;
        hit_next            = hit_reg;
        up_next             = up_reg;
        cnt_next            = cnt_reg;
        pos_next            = pos_reg;
        rem_next            = rem_reg;
        den_next            = den_reg;
        quot_next           = quot_reg;
        step_next           = step_reg;
        out_valid_next      = out_valid_reg && out_stall;
        crossing_next       = crossing_reg;
        upward_next         = upward_reg;
        crossing_count_next = crossing_count_reg;
        position_next       = position_reg;
        fraction_next       = fraction_reg;
        out_channel_next    = out_channel_reg;

        if (cfg_write)
        begin
            threshold_next = pwdata[THR_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ch_next     = channel;
                    sample_next = sample;
                    last_next   = block_end;
                    state_next  = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                hit_next  = hit;
                up_next   = hit_up;
                cnt_next  = hit ? count_reg[ch_idx] : '0;
                pos_next  = hit ? bpos_reg[ch_idx] : '0;
                rem_next  = num;
                den_next  = den;
                quot_next = '0;
                step_next = '0;
                if (ch_ok)
                begin
                    if (hit)
                    begin
                        count_next[ch_idx] = count_reg[ch_idx] + COUNT_W'(1);
                    end
                    prev_next[ch_idx] = sample_reg;
                    if (last_reg)
                    begin
                        bpos_next[ch_idx] = '0;
                    end
                    else if (bpos_reg[ch_idx] < POS_LIMIT)
                    begin
                        bpos_next[ch_idx] = bpos_reg[ch_idx] + POS_W'(1);
                    end
                end
                if (hit && (den > 0) && (num < den) && (num > 0))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    quot_next  = (hit && ((den <= 0) || (num >= den))) ? FRAC_MAX : '0;
                    state_next = ST_FINISH;
                end
            end

            ST_DIV:
            begin
                if (!rem_diff[DW])
                begin
                    rem_next  = rem_diff[DW-1:0];
                    quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[DW-1:0];
                    quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    crossing_next       = hit_reg;
                    upward_next         = up_reg;
                    crossing_count_next = cnt_reg;
                    position_next       = pos_reg;
                    fraction_next       = quot_reg;
                    out_channel_next    = ch_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            threshold_reg      <= THR_RESET;
            out_valid_reg      <= 1'b0;
            crossing_reg       <= 1'b0;
            upward_reg         <= 1'b0;
            crossing_count_reg <= '0;
            position_reg       <= '0;
            fraction_reg       <= '0;
            out_channel_reg    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c] <= '0;
                prev_reg[c]  <= '0;
                bpos_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg          <= state_next;
            threshold_reg      <= threshold_next;
            out_valid_reg      <= out_valid_next;
            crossing_reg       <= crossing_next;
            upward_reg         <= upward_next;
            crossing_count_reg <= crossing_count_next;
            position_reg       <= position_next;
            fraction_reg       <= fraction_next;
            out_channel_reg    <= out_channel_next;
            count_reg          <= count_next;
            prev_reg           <= prev_next;
            bpos_reg           <= bpos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg             <= ch_next;
        sample_reg         <= sample_next;
        last_reg           <= last_next;
        hit_reg            <= hit_next;
        up_reg             <= up_next;
        cnt_reg            <= cnt_next;
        pos_reg            <= pos_next;
        rem_reg            <= rem_next;
        den_reg            <= den_next;
        quot_reg           <= quot_next;
        step_reg           <= step_next;
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign crossing       = crossing_reg;
    assign upward         = upward_reg;
    assign crossing_count = crossing_count_reg;
    assign position       = position_reg;
    assign fraction       = fraction_reg;
    assign out_channel    = out_channel_reg;

endmodule
